// ----- hw/rtl/tsfm_pkg.sv -----
// shared types and constants for the touch sample filter and mapper
// used by tsfm_ctrl, tsfm_dp and the top level; no dependencies
package tsfm_pkg;

  localparam int unsigned DW        = 12;   // width of one raw reading
  localparam int unsigned IN_W      = 144;  // twelve readings packed
  localparam int unsigned OUT_W     = 32;   // column, row, pressure padded
  localparam int unsigned PROD_W    = 24;   // offset-corrected reading times screen top
  localparam int unsigned DIV_STEPS = PROD_W / 2;  // two quotient bits a step
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  localparam logic [DW-1:0] MAX12   = 12'hFFF;
  localparam logic [15:0]   RECIP3  = 16'd43691;  // ceil(2^17 / 3)

  localparam logic [8:0] HELD_X_RST = 9'd160;
  localparam logic [7:0] HELD_Y_RST = 8'd120;

  localparam int unsigned ORI_SWAP = 0;
  localparam int unsigned ORI_INVX = 1;
  localparam int unsigned ORI_INVY = 2;

  localparam logic [DW-1:0] X_OFFSET_RST = 12'd351;
  localparam logic [DW-1:0] X_SPAN_RST   = 12'd3465;
  localparam logic [DW-1:0] Y_OFFSET_RST = 12'd306;
  localparam logic [DW-1:0] Y_SPAN_RST   = 12'd3446;
  localparam logic [2:0]    ORIENT_RST   = 3'd7;
  localparam logic [DW-1:0] THRESH_RST   = 12'd350;

  typedef enum logic [2:0] {
    REG_X_OFFSET,
    REG_X_SPAN,
    REG_Y_OFFSET,
    REG_Y_SPAN,
    REG_ORIENT,
    REG_THRESH,
    REG_CALIB_HOLD
  } cfg_reg_t;

  typedef struct packed {
    logic [DW-1:0] x_off;
    logic [DW-1:0] x_span;
    logic [DW-1:0] y_off;
    logic [DW-1:0] y_span;
    logic [2:0]    orient;
    logic [DW-1:0] thresh;
    logic          calib;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MID,
    S_AVG,
    S_PROD,
    S_LDX,
    S_DIVX,
    S_LDY,
    S_DIVY,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;       // capture the input word
    logic mid;        // pressure check and middle-three sums
    logic avg;        // divide sums by three
    logic prod;       // offset subtract and scale products
    logic div_load;   // start the divider
    logic div_step;   // one radix-4 divider step
    logic sel_y;      // divider works on the second screen axis
    logic store_x;    // keep first-axis quotient
    logic out_load;   // fill the result register
  } ctrl_cmd_t;

endpackage

// ----- hw/rtl/tsfm_ctrl.sv -----
// sequencer for the touch sample filter: walks the datapath through its steps
// and owns the input/output handshakes; depends on tsfm_pkg
module tsfm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output tsfm_pkg::ctrl_cmd_t  cmd
);
  import tsfm_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MID;
        end
      end
      S_MID: begin
        cmd.mid   = 1'b1;
        state_nxt = S_AVG;
      end
      S_AVG: begin
        cmd.avg   = 1'b1;
        state_nxt = S_PROD;
      end
      S_PROD: begin
        cmd.prod  = 1'b1;
        state_nxt = S_LDX;
      end
      S_LDX: begin
        cmd.div_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIVX;
      end
      S_DIVX: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_LDY;
        end
      end
      S_LDY: begin
        cmd.store_x  = 1'b1;
        cmd.div_load = 1'b1;
        cmd.sel_y    = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIVY;
      end
      S_DIVY: begin
        cmd.div_step = 1'b1;
        cmd.sel_y    = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // wait for the result register to drain
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;

  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_MID)
    else $error("accepted word did not start processing");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result register overwritten while still held");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIVX || state_r == S_DIVY) |-> cnt_r <= CNT_W'(DIV_STEPS - 1))
    else $error("divider step count out of range");

endmodule

// ----- hw/rtl/tsfm_dp.sv -----
// datapath of the touch sample filter: pressure check, trimmed mean,
// scaling with a shared radix-4 divider, held coordinates; depends on tsfm_pkg
module tsfm_dp #(
  parameter int unsigned SCREEN_WIDTH  = 320,
  parameter int unsigned SCREEN_HEIGHT = 240
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tsfm_pkg::ctrl_cmd_t        cmd,
  input  tsfm_pkg::cfg_t             cfg,
  input  logic [tsfm_pkg::IN_W-1:0]  in_data,
  output logic                       out_touched,
  output logic [8:0]                 out_x,
  output logic [7:0]                 out_y,
  output logic [tsfm_pkg::DW-1:0]    out_press
);
  import tsfm_pkg::*;

  localparam logic [DW-1:0] TOP_X = DW'(SCREEN_WIDTH - 1);
  localparam logic [DW-1:0] TOP_Y = DW'(SCREEN_HEIGHT - 1);

  function automatic logic [13:0] mid3_sum(input logic [4:0][DW-1:0] s);
    logic [14:0]   tot;
    logic [DW-1:0] mn;
    logic [DW-1:0] mx;
    logic [14:0]   r;
    tot = '0;
    mn  = s[0];
    mx  = s[0];
    for (int i = 0; i < 5; i++) begin
      tot = tot + 15'(s[i]);
      if (s[i] < mn) mn = s[i];
      if (s[i] > mx) mx = s[i];
    end
    // sum of the middle three is the total less the extremes
    r = tot - 15'(mn) - 15'(mx);
    return r[13:0];
  endfunction

  function automatic logic [DW-1:0] fin_axis(input logic [PROD_W-1:0] q,
                                             input logic [DW-1:0] top,
                                             input logic inv);
    logic [PROD_W-1:0] t;
    logic [PROD_W-1:0] v;
    t = PROD_W'(top);
    v = q;
    if (inv) v = (v > t) ? '0 : t - v;
    if (v > t) v = t;
    return v[DW-1:0];
  endfunction

  // captured input word
  logic [DW-1:0]         pa_r, pb_r;
  logic [4:0][DW-1:0]    xs_r, ys_r;

  logic [13:0]           mid_x_r, mid_y_r;
  logic [DW-1:0]         press_r;
  logic                  ok_r;
  logic [DW-1:0]         avg_x_r, avg_y_r;
  logic [PROD_W-1:0]     prod_x_r, prod_y_r;

  logic [PROD_W-1:0]     dd_r, q_r, qx_r;
  logic [DW-1:0]         rem_r;

  logic [8:0]            held_x_r;
  logic [7:0]            held_y_r;
  logic                  out_touched_r;
  logic [8:0]            out_x_r;
  logic [7:0]            out_y_r;
  logic [DW-1:0]         out_press_r;

  // pressure and touch decision
  logic [DW:0]           z_raw;
  logic                  ok_nxt;
  logic [DW-1:0]         press_nxt;

  assign z_raw     = {1'b0, pa_r} + {1'b0, MAX12} - {1'b0, pb_r};
  assign ok_nxt    = !cfg.calib && (pa_r != '0) && (pb_r != '0) &&
                     (z_raw >= {1'b0, cfg.thresh}) &&
                     (cfg.x_span != '0) && (cfg.y_span != '0);
  assign press_nxt = (z_raw > {1'b0, MAX12}) ? MAX12 : z_raw[DW-1:0];

  // divide by three through the reciprocal
  logic [29:0] px, py;
  assign px = 30'(mid_x_r) * 30'(RECIP3);
  assign py = 30'(mid_y_r) * 30'(RECIP3);

  // swap, offset and scale
  logic [DW-1:0] a_sel, b_sel, da, db;
  assign a_sel = cfg.orient[ORI_SWAP] ? avg_y_r : avg_x_r;
  assign b_sel = cfg.orient[ORI_SWAP] ? avg_x_r : avg_y_r;
  assign da    = (a_sel > cfg.x_off) ? a_sel - cfg.x_off : '0;
  assign db    = (b_sel > cfg.y_off) ? b_sel - cfg.y_off : '0;

  // radix-4 restoring divider step
  logic [DW-1:0] span;
  logic [DW:0]   t1, t2, r1, r2;
  logic          ge1, ge2;

  assign span = cmd.sel_y ? cfg.y_span : cfg.x_span;
  assign t1   = {rem_r, dd_r[PROD_W-1]};
  assign ge1  = t1 >= {1'b0, span};
  assign r1   = ge1 ? t1 - {1'b0, span} : t1;
  assign t2   = {r1[DW-1:0], dd_r[PROD_W-2]};
  assign ge2  = t2 >= {1'b0, span};
  assign r2   = ge2 ? t2 - {1'b0, span} : t2;

  // final mapping
  logic [DW-1:0] sx, sy;
  assign sx = fin_axis(qx_r, TOP_X, cfg.orient[ORI_INVX]);
  assign sy = fin_axis(q_r,  TOP_Y, cfg.orient[ORI_INVY]);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pa_r <= in_data[DW-1:0];
      pb_r <= in_data[2*DW-1:DW];
      for (int i = 0; i < 5; i++) begin
        xs_r[i] <= in_data[(2+i)*DW +: DW];
        ys_r[i] <= in_data[(7+i)*DW +: DW];
      end
    end
    if (cmd.mid) begin
      mid_x_r <= mid3_sum(xs_r);
      mid_y_r <= mid3_sum(ys_r);
      press_r <= press_nxt;
      ok_r    <= ok_nxt;
    end
    if (cmd.avg) begin
      avg_x_r <= px[28:17];
      avg_y_r <= py[28:17];
    end
    if (cmd.prod) begin
      prod_x_r <= PROD_W'(da) * PROD_W'(TOP_X);
      prod_y_r <= PROD_W'(db) * PROD_W'(TOP_Y);
    end
    if (cmd.store_x) begin
      qx_r <= q_r;
    end
    if (cmd.div_load) begin
      dd_r  <= cmd.sel_y ? prod_y_r : prod_x_r;
      q_r   <= '0;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      dd_r  <= {dd_r[PROD_W-3:0], 2'b00};
      q_r   <= {q_r[PROD_W-3:0], ge1, ge2};
      rem_r <= r2[DW-1:0];
    end
    if (cmd.out_load) begin
      out_x_r <= ok_r ? sx[8:0] : held_x_r;
      out_y_r <= ok_r ? sy[7:0] : held_y_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_x_r      <= HELD_X_RST;
      held_y_r      <= HELD_Y_RST;
      out_touched_r <= 1'b0;
      out_press_r   <= '0;
    end else if (cmd.out_load) begin
      out_touched_r <= ok_r;
      out_press_r   <= ok_r ? press_r : '0;
      if (ok_r) begin
        held_x_r <= sx[8:0];
        held_y_r <= sy[7:0];
      end
    end
  end

  assign out_touched = out_touched_r;
  assign out_x       = out_x_r;
  assign out_y       = out_y_r;
  assign out_press   = out_press_r;

  a_press_matches_touch: assert property (@(posedge clk) disable iff (!rst_n)
    out_touched_r == (out_press_r != '0))
    else $error("pressure and touch flag disagree");

  a_held_follows_touch: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && ok_r) |=> (held_x_r == out_x_r && held_y_r == out_y_r))
    else $error("held coordinates not updated with a touch");

endmodule

// ----- hw/rtl/touch_sample_filter_and_mapper.sv -----
// A sample word is taken only in the idle state, so the next one enters once
// the previous result is in the result register. The shared radix-4 divider
// runs 12 steps per screen axis, once for X and once for Y. The result
// register lets the next word enter while a result waits. Synchronous
// active-low reset restores the register defaults and the held coordinates
// (160, 120); no clearing pass is needed.
module touch_sample_filter_and_mapper #(
  parameter int unsigned SCREEN_WIDTH  = 320,
  parameter int unsigned SCREEN_HEIGHT = 240
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // press_a, press_b, x_sample_0..4, y_sample_0..4 (12 bits each)
  input  logic [tsfm_pkg::IN_W-1:0]  in_tdata,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // column [8:0], row [16:9], pressure [28:17], zero pad
  output logic [tsfm_pkg::OUT_W-1:0] out_tdata,
  // touched
  output logic                       out_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [2:0]                 cfg_index,
  input  logic [tsfm_pkg::DW-1:0]    cfg_data
);
  import tsfm_pkg::*;

  cfg_t      cfg_r;
  ctrl_cmd_t cmd;
  logic [8:0]    res_x;
  logic [7:0]    res_y;
  logic [DW-1:0] res_press;
  logic          res_touched;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_off  <= X_OFFSET_RST;
      cfg_r.x_span <= X_SPAN_RST;
      cfg_r.y_off  <= Y_OFFSET_RST;
      cfg_r.y_span <= Y_SPAN_RST;
      cfg_r.orient <= ORIENT_RST;
      cfg_r.thresh <= THRESH_RST;
      cfg_r.calib  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_X_OFFSET:   cfg_r.x_off  <= cfg_data;
        REG_X_SPAN:     cfg_r.x_span <= cfg_data;
        REG_Y_OFFSET:   cfg_r.y_off  <= cfg_data;
        REG_Y_SPAN:     cfg_r.y_span <= cfg_data;
        REG_ORIENT:     cfg_r.orient <= cfg_data[2:0];
        REG_THRESH:     cfg_r.thresh <= cfg_data;
        REG_CALIB_HOLD: cfg_r.calib  <= cfg_data[0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  tsfm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  tsfm_dp #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cfg         (cfg_r),
    .in_data     (in_tdata),
    .out_touched (res_touched),
    .out_x       (res_x),
    .out_y       (res_y),
    .out_press   (res_press)
  );

  assign out_tdata = {3'b000, res_press, res_y, res_x};
  assign out_tuser = res_touched;

endmodule
